// ===== hdl/frs_pkg.sv =====
// Package for the fitness roulette selector: request/result structs, command codes,
// population constants. No dependencies.
`default_nettype none
package frs_pkg;
	localparam int unsigned PopSize  = 256;
	localparam int unsigned SlotW    = $clog2(PopSize);
	localparam int unsigned CountW   = $clog2(PopSize + 1);
	localparam int unsigned StoreW   = 33;
	localparam int unsigned TotalW   = 40;
	localparam int unsigned AccW     = 48;

	typedef enum logic [1:0] {
		CMD_LOAD      = 2'd0,
		CMD_NORMALIZE = 2'd1,
		CMD_SELECT    = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] fitness_value;
		logic [15:0]        random_fraction;
	} req_t;

	typedef struct packed {
		logic [7:0]        selected_index;
		logic [7:0]        lowest_index;
		logic [7:0]        highest_index;
		logic [TotalW-1:0] fitness_total;
		logic              full_error;
	} rsp_t;

	// Control handed down the scan chain
	typedef struct packed {
		logic              live;
		logic              norm;
		logic [SlotW-1:0]  idx;
	} scan_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_DONE = 2'd2
	} state_t;
endpackage
`default_nettype wire

// ===== hdl/frs_cell.sv =====
// One scan cell: holds one population slot and its normalize step.
// Depends on frs_pkg.
`default_nettype none
module frs_cell (
	input  wire logic                          clk,
	input  wire logic                          load_en,
	input  wire logic signed [31:0]            load_value,
	input  wire logic                          tok_in,
	input  wire logic                          norm,
	input  wire logic signed [31:0]            min_value,
	output logic signed [frs_pkg::StoreW-1:0]  value,
	output logic                               tok_out
);
	import frs_pkg::*;

	logic signed [StoreW-1:0] value_q;
	logic                     tok_q;

	// Hold slot value; subtract minimum when the scan token passes on normalize
	always_ff @(posedge clk) begin
		if (load_en) begin
			value_q <= StoreW'(load_value);
		end else if (tok_in && norm) begin
			value_q <= value_q - StoreW'(min_value);
		end
	end

	// Advance the token one cell per cycle
	always_ff @(posedge clk) begin
		tok_q <= tok_in;
	end

	assign value   = value_q;
	assign tok_out = tok_q;
endmodule
`default_nettype wire

// ===== hdl/frs_scan.sv =====
// Shared accumulator fed by the tapped cell slot: running sum and compare.
// Depends on frs_pkg.
`default_nettype none
module frs_scan (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire frs_pkg::scan_t                     step,
	input  wire logic signed [frs_pkg::StoreW-1:0]  value,
	input  wire logic signed [frs_pkg::AccW-1:0]    point,
	output logic signed [frs_pkg::AccW-1:0]         acc,
	output logic                                    found,
	output logic [frs_pkg::SlotW-1:0]               hit_idx
);
	import frs_pkg::*;

	logic signed [AccW-1:0] acc_q;
	logic signed [AccW-1:0] acc_d;
	logic                   found_q;
	logic [SlotW-1:0]       hit_q;

	assign acc_d = acc_q + AccW'(value);

	// Accumulate each live slot; on select, remember the first sum above the point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			found_q <= 1'b0;
			hit_q   <= '0;
		end else if (start) begin
			acc_q   <= '0;
			found_q <= 1'b0;
			hit_q   <= '0;
		end else if (step.live) begin
			acc_q <= acc_d;
			if (!step.norm && !found_q && acc_d > point) begin
				found_q <= 1'b1;
				hit_q   <= step.idx;
			end
		end
	end

	assign acc     = acc_q;
	assign found   = found_q;
	assign hit_idx = hit_q;
endmodule
`default_nettype wire

// ===== hdl/fitness_roulette_selector_top.sv =====
// Top level of the fitness roulette selector: command control, tracking, cell chain.
// Depends on frs_pkg, frs_cell, frs_scan.
//
// channel | signals           | payload
// req     | req_valid/ready   | req_t (command, fitness_value, random_fraction)
// rsp     | rsp_valid/ready   | rsp_t (indices, fitness_total, full_error)
//
// Load and clear, and normalize or select on an empty store, answer straight from
// the request; otherwise a scan position steps one slot per cycle into a single
// accumulator while a token walks the cell chain to apply the normalize step.
// Reset clears counts and tracking; slot contents are undefined until loaded.
// A request is taken only when idle and when the output register is empty or
// drains in the same cycle, so a held result stalls the request side.
`default_nettype none
module fitness_roulette_selector_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire frs_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output frs_pkg::rsp_t      rsp
);
	import frs_pkg::*;

	state_t state_q, state_d;
	logic [CountW-1:0]        count_q;
	logic signed [31:0]       min_q, max_q;
	logic [SlotW-1:0]         min_slot_q, max_slot_q;
	logic [TotalW-1:0]        total_q;
	logic                     norm_q;
	logic signed [AccW-1:0]   point_q;
	logic [CountW-1:0]        pos_q;
	logic                     out_full;
	rsp_t                     rsp_q;
	logic                     rsp_valid_q;

	logic                     take;
	logic                     start;
	logic                     finish;
	logic                     rsp_set;
	logic [PopSize:0]         tok;
	logic signed [StoreW-1:0] cell_val [PopSize];
	logic signed [StoreW-1:0] tap;
	scan_t                    step;
	logic signed [AccW-1:0]   acc;
	logic                     found;
	logic [SlotW-1:0]         hit_idx;
	logic [TotalW-1:0]        sat_total;

	assign out_full  = rsp_valid_q && !rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && !out_full;
	assign take      = req_valid && req_ready;
	assign start     = take && (req.command == CMD_NORMALIZE || req.command == CMD_SELECT)
		&& count_q != '0;
	assign tok[0]    = start;
	assign finish    = (state_q == ST_DONE) && !step.live;
	assign rsp_set   = (take && (req.command == CMD_LOAD || req.command == CMD_CLEAR
		|| count_q == '0)) || finish;

	// Cell chain: token walks one slot per cycle
	for (genvar g = 0; g < PopSize; g++) begin : g_cell
		frs_cell u_cell (
			.clk       (clk),
			.load_en   (take && req.command == CMD_LOAD && count_q == CountW'(g)),
			.load_value(req.fitness_value),
			.tok_in    (tok[g] && CountW'(g) < count_q),
			.norm      (start ? (req.command == CMD_NORMALIZE) : norm_q),
			.min_value (min_q),
			.value     (cell_val[g]),
			.tok_out   (tok[g+1])
		);
	end

	// Sample the slot the token just left (post-normalize value)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step <= '0;
		end else begin
			step.live <= (state_q == ST_SCAN) && pos_q < count_q;
			step.norm <= norm_q;
			step.idx  <= pos_q[SlotW-1:0];
		end
	end
	always_ff @(posedge clk) begin
		tap <= cell_val[pos_q[SlotW-1:0]];
	end

	frs_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.step   (step),
		.value  (tap),
		.point  (point_q),
		.acc    (acc),
		.found  (found),
		.hit_idx(hit_idx)
	);

	always_comb begin
		if (acc < 0) sat_total = '0;
		else if (acc > AccW'(48'hFF_FFFF_FFFF)) sat_total = '1;
		else sat_total = acc[TotalW-1:0];
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_SCAN;
			ST_SCAN: if (pos_q + 1'b1 >= count_q) state_d = ST_DONE;
			ST_DONE: if (!step.live) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Tracking, scan position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			min_q       <= 32'sh7FFF_FFFF;
			max_q       <= '0;
			min_slot_q  <= '0;
			max_slot_q  <= '0;
			total_q     <= '0;
			norm_q      <= 1'b0;
			point_q     <= '0;
			pos_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_set) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			if (state_q == ST_SCAN) pos_q <= pos_q + 1'b1;
			if (take) begin
				case (cmd_t'(req.command))
					CMD_LOAD: begin
						rsp_q.fitness_total <= total_q;
						if (count_q >= CountW'(PopSize)) begin
							rsp_q.selected_index <= 8'd0;
							rsp_q.full_error     <= 1'b1;
							rsp_q.lowest_index  <= 8'(min_slot_q);
							rsp_q.highest_index <= 8'(max_slot_q);
						end else begin
							rsp_q.selected_index <= 8'(count_q);
							rsp_q.full_error     <= 1'b0;
							rsp_q.lowest_index  <= (req.fitness_value < min_q) ?
								8'(count_q) : 8'(min_slot_q);
							rsp_q.highest_index <= (req.fitness_value > max_q) ?
								8'(count_q) : 8'(max_slot_q);
							if (req.fitness_value < min_q) begin
								min_q <= req.fitness_value;
								min_slot_q <= count_q[SlotW-1:0];
							end
							if (req.fitness_value > max_q) begin
								max_q <= req.fitness_value;
								max_slot_q <= count_q[SlotW-1:0];
							end
							count_q <= count_q + 1'b1;
						end
					end
					CMD_NORMALIZE, CMD_SELECT: begin
						norm_q  <= req.command == CMD_NORMALIZE;
						point_q <= AccW'((total_q * 56'(req.random_fraction)) >> 16);
						pos_q   <= '0;
						if (count_q == '0) begin
							if (req.command == CMD_NORMALIZE) total_q <= '0;
							rsp_q.selected_index <= 8'd0;
							rsp_q.full_error     <= 1'b0;
							rsp_q.fitness_total <= (req.command == CMD_NORMALIZE) ?
								'0 : total_q;
							rsp_q.lowest_index  <= 8'(min_slot_q);
							rsp_q.highest_index <= 8'(max_slot_q);
						end
					end
					CMD_CLEAR: begin
						count_q    <= '0;
						min_q      <= 32'sh7FFF_FFFF;
						max_q      <= '0;
						min_slot_q <= '0;
						max_slot_q <= '0;
						total_q    <= '0;
						rsp_q      <= '0;
					end
					default: ;
				endcase
			end
			// Finish a scan once the last sampled slot is accumulated
			if (finish) begin
				rsp_q.selected_index <= (!norm_q && found) ? 8'(hit_idx) : 8'd0;
				rsp_q.lowest_index   <= 8'(min_slot_q);
				rsp_q.highest_index  <= 8'(max_slot_q);
				rsp_q.full_error     <= 1'b0;
				rsp_q.fitness_total  <= norm_q ? sat_total : total_q;
				if (norm_q) total_q <= sat_total;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(PopSize)) else $error("entry count beyond population");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !req_ready) else $error("request taken during scan");
	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !step.live) |=> rsp_valid) else $error("scan lost result");
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.full_error |-> count_q == CountW'(PopSize))
		else $error("full flag with room left");
`endif
endmodule
`default_nettype wire

// ===== tb/fitness_roulette_selector_top_test.sv =====
// Testbench for the fitness roulette selector: directed and random requests with a
// built-in predictor, random idling on both channels. Depends on frs_pkg and the top level.
`timescale 1ns / 100ps
`default_nettype none
module fitness_roulette_selector_top_test;
	import frs_pkg::*;

	localparam int unsigned CycleLimit = 3_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	req_t req = '0;
	logic req_ready;
	logic rsp_valid;
	rsp_t rsp;

	fitness_roulette_selector_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #6 clk = ~clk;

	// predictor state
	logic signed [StoreW-1:0] slot_value [PopSize];
	int unsigned fill_count;
	logic signed [31:0] low_value, high_value;
	int unsigned low_slot, high_slot;
	logic [TotalW-1:0] running_total;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit stimulus_done = 1'b0;
	bit calm_phase = 1'b0;
	bit hold_sender = 1'b0;
	int unsigned send_gap = 0, recv_gap = 0;

	// acceptance flag seen at the last rising edge
	logic req_ready_seen = 1'b0;

	function automatic void clear_tracking();
		fill_count = 0;
		low_value = 32'sh7FFF_FFFF;
		high_value = '0;
		low_slot = 0;
		high_slot = 0;
		running_total = '0;
	endfunction

	// compute the result of one accepted request and advance the predictor
	function automatic rsp_t roulette_predict(req_t r);
		rsp_t o;
		logic signed [63:0] acc, point;
		logic [63:0] prod;
		o = '0;
		case (cmd_t'(r.command))
			CMD_LOAD: begin
				if (fill_count >= PopSize) begin
					o.full_error = 1'b1;
				end else begin
					if (r.fitness_value > high_value) begin
						high_slot = fill_count;
						high_value = r.fitness_value;
					end
					if (r.fitness_value < low_value) begin
						low_slot = fill_count;
						low_value = r.fitness_value;
					end
					slot_value[fill_count] = StoreW'(r.fitness_value);
					o.selected_index = 8'(fill_count);
					fill_count++;
				end
			end
			CMD_NORMALIZE: begin
				acc = 0;
				for (int i = 0; i < fill_count; i++) begin
					slot_value[i] = slot_value[i] - StoreW'(low_value);
					acc += 64'(slot_value[i]);
				end
				if (acc < 0) acc = 0;
				if (acc > 64'sh0FF_FFFF_FFFF) acc = 64'sh0FF_FFFF_FFFF;
				running_total = TotalW'(acc);
			end
			CMD_SELECT: begin
				prod = 64'(running_total) * 64'(r.random_fraction);
				point = $signed(prod >> 16);
				acc = 0;
				for (int i = 0; i < fill_count; i++) begin
					acc += 64'(slot_value[i]);
					if (acc > point) begin
						o.selected_index = 8'(i);
						break;
					end
				end
			end
			default: clear_tracking();
		endcase
		o.lowest_index = 8'(low_slot);
		o.highest_index = 8'(high_slot);
		o.fitness_total = running_total;
		return o;
	endfunction

	function automatic req_t make_req(cmd_t c, logic [31:0] f, logic [15:0] r);
		req_t q;
		q.command = c;
		q.fitness_value = f;
		q.random_fraction = r;
		return q;
	endfunction

	function automatic logic [31:0] rand_fitness();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 255)) - 32'd128;
			default: return $urandom();
		endcase
	endfunction

	// fill the request queue in phases
	initial begin
		int n;
		clear_tracking();
		pending_reqs.push_back(make_req(CMD_SELECT, '0, 16'hFFFF));
		pending_reqs.push_back(make_req(CMD_NORMALIZE, '0, '0));
		pending_reqs.push_back(make_req(CMD_LOAD, 32'hFFFF_0000, '0));
		pending_reqs.push_back(make_req(CMD_LOAD, 32'h8000_0000, '0));
		pending_reqs.push_back(make_req(CMD_LOAD, 32'h8000_0000, '0));
		pending_reqs.push_back(make_req(CMD_LOAD, 32'h7FFF_FFFF, '0));
		pending_reqs.push_back(make_req(CMD_LOAD, 32'h7FFF_FFFF, '0));
		pending_reqs.push_back(make_req(CMD_LOAD, 32'h0001_0000, '0));
		pending_reqs.push_back(make_req(CMD_NORMALIZE, '0, '0));
		pending_reqs.push_back(make_req(CMD_SELECT, '0, '0));
		pending_reqs.push_back(make_req(CMD_SELECT, '0, 16'hFFFF));
		pending_reqs.push_back(make_req(CMD_SELECT, '0, 16'h8000));
		pending_reqs.push_back(make_req(CMD_NORMALIZE, '0, '0));
		pending_reqs.push_back(make_req(CMD_SELECT, '0, 16'h5555));
		pending_reqs.push_back(make_req(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF));
		// fill the store to capacity and overflow it
		for (int i = 0; i < PopSize + 3; i++)
			pending_reqs.push_back(make_req(CMD_LOAD, rand_fitness(), '0));
		pending_reqs.push_back(make_req(CMD_NORMALIZE, '0, '0));
		for (int i = 0; i < 4; i++)
			pending_reqs.push_back(make_req(CMD_SELECT, '0, 16'($urandom())));
		pending_reqs.push_back(make_req(CMD_CLEAR, '0, '0));
		// wait for a drain before the random part
		wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
		hold_sender = 1'b1;
		repeat (4) @(posedge clk);
		hold_sender = 1'b0;
		// random populations: mostly small, load-normalize-select sessions
		while (pending_reqs.size() < 500) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(0, 10);
			for (int i = 0; i < n; i++)
				pending_reqs.push_back(make_req(CMD_LOAD, rand_fitness(), 16'($urandom())));
			if ($urandom_range(0, 4) != 0)
				pending_reqs.push_back(make_req(CMD_NORMALIZE, $urandom(), 16'($urandom())));
			if ($urandom_range(0, 6) == 0)
				pending_reqs.push_back(make_req(CMD_NORMALIZE, $urandom(), 16'($urandom())));
			repeat ($urandom_range(1, 4))
				pending_reqs.push_back(make_req(CMD_SELECT, $urandom(), 16'($urandom())));
			if ($urandom_range(0, 5) == 0)
				pending_reqs.push_back(make_req(cmd_t'($urandom_range(0, 3)), $urandom(),
					16'($urandom())));
			pending_reqs.push_back(make_req(CMD_CLEAR, $urandom(), 16'($urandom())));
		end
		wait (pending_reqs.size() < 60);
		calm_phase = 1'b1;
		wait (pending_reqs.size() == 0);
		stimulus_done = 1'b1;
	end

	// reset
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: present requests at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_ready_seen) begin
				// hold the request until accepted
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && !hold_sender) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				if (!calm_phase && $urandom_range(0, 7) == 0)
					send_gap <= $urandom_range(1, 5);
			end else begin
				req_valid <= 1'b0;
			end
			// receiver idling
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (!calm_phase && $urandom_range(0, 7) == 0)
					recv_gap <= $urandom_range(1, 5);
			end
		end
	end

	// monitor: predict on request, check on result
	always @(posedge clk) begin
		rsp_t want;
		cycle_count <= cycle_count + 1;
		req_ready_seen <= req_valid && req_ready;
		if (req_valid && req_ready)
			expected_rsps.push_back(roulette_predict(req));
		if (rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", rsp);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.selected_index !== want.selected_index
						|| rsp.lowest_index !== want.lowest_index
						|| rsp.highest_index !== want.highest_index
						|| rsp.fitness_total !== want.fitness_total
						|| rsp.full_error !== want.full_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p got %p", want, rsp);
				end
			end
		end
	end

	// end of run
	initial begin
		wait (stimulus_done && !req_valid && expected_rsps.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// timeout
	initial begin
		wait (cycle_count >= CycleLimit);
		$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/frs_pkg.sv
hdl/frs_cell.sv
hdl/frs_scan.sv
hdl/fitness_roulette_selector_top.sv
tb/fitness_roulette_selector_top_test.sv
